[hw/rtl/mpmm_pkg.sv]
// Shared types and constants of the message pool and mailbox manager.
package mpmm_pkg;

    localparam int OP_W        = 2;
    localparam int ID_W        = 8;
    localparam int MSG_IN_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int POOL_CFG_W  = 7;
    localparam int MBOX_CFG_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int TDATA_IN_W  = 56;
    localparam int TDATA_OUT_W = 56;
    localparam int NUM_POOL_CFG = 4;

    localparam logic [OP_W-1:0] OP_INIT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND = 2'd1;
    localparam logic [OP_W-1:0] OP_RECV = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MBOX_EMPTY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_IDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNALS  = 3'd5;

    localparam logic [POOL_CFG_W-1:0] POOL_CFG_RESET = 7'd16;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DECODE    = 6'b000010,
        S_UPDATE    = 6'b000100,
        S_INIT_POOL = 6'b001000,
        S_INIT_BUF  = 6'b010000,
        S_DONE      = 6'b100000
    } t_state;

endpackage

[hw/rtl/mpmm_buf_mem.sv]
// Buffer store: link memory plus message and owner memory, each one write and one read port.
module mpmm_buf_mem #(
    parameter int DEPTH  = 64,
    parameter int BUF_W  = 6,
    parameter int MSG_W  = 32,
    parameter int POOL_W = 2
) (
    input  logic              i_clk,
    input  logic [BUF_W-1:0]  i_rd_addr,
    input  logic              i_link_we,
    input  logic [BUF_W-1:0]  i_link_waddr,
    input  logic [BUF_W-1:0]  i_link_wdata,
    output logic [BUF_W-1:0]  o_link_rdata,
    input  logic              i_data_we,
    input  logic [BUF_W-1:0]  i_data_waddr,
    input  logic [MSG_W-1:0]  i_data_wmsg,
    input  logic [POOL_W-1:0] i_data_wowner,
    output logic [MSG_W-1:0]  o_data_rmsg,
    output logic [POOL_W-1:0] o_data_rowner
);

    logic [BUF_W-1:0]        r_link_mem  [DEPTH];
    logic [MSG_W+POOL_W-1:0] r_data_mem  [DEPTH];
    logic [BUF_W-1:0]        r_link_rd;
    logic [MSG_W+POOL_W-1:0] r_data_rd;

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            r_link_mem[i_link_waddr] <= i_link_wdata;
        end
        r_link_rd <= r_link_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_data_we) begin
            r_data_mem[i_data_waddr] <= {i_data_wmsg, i_data_wowner};
        end
        r_data_rd <= r_data_mem[i_rd_addr];
    end

    assign o_link_rdata  = r_link_rd;
    assign o_data_rmsg   = r_data_rd[MSG_W+POOL_W-1:POOL_W];
    assign o_data_rowner = r_data_rd[POOL_W-1:0];

endmodule

[hw/rtl/message_pool_mailbox_manager.sv]
// A send or receive goes from decode to update (a link read, then a write) and on to done;
// a bad id, an empty pool or an empty mailbox goes from decode straight to done, and an init
// walks the pools and their buffers before done. One item at a time: a new item is taken only
// in idle, and done waits until the output register has room.
// Reset (synchronous, active low) empties all pools and mailboxes and sets the configuration
// to its defaults; the buffer store itself is not cleared and is only read after being written.
module message_pool_mailbox_manager #(
    parameter int NUM_POOLS     = 4,
    parameter int NUM_MAILBOXES = 8,
    parameter int NUM_BUFFERS   = 64,
    parameter int MESSAGE_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input item: operation[1:0], mailbox_id[9:2], pool_id[17:10], message_in[49:18],
    // zero fill above.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [mpmm_pkg::TDATA_IN_W-1:0]    i_s_tdata,
    // Result item: status[1:0], message_out[33:2], notify_valid[34], notify_task[42:35],
    // notify_signal[50:43], zero fill above.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mpmm_pkg::TDATA_OUT_W-1:0]   o_m_tdata,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [mpmm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mpmm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Buffer index, count, pool index, pool counter and mailbox index widths.
    localparam int BW  = $clog2(NUM_BUFFERS);
    localparam int CW  = $clog2(NUM_BUFFERS + 1);
    localparam int PW  = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int PCW = $clog2(NUM_POOLS + 1);
    localparam int MW  = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
    // Width in which a configured pool count is compared with the buffers left.
    localparam int LW  = (CW > mpmm_pkg::POOL_CFG_W) ? CW : mpmm_pkg::POOL_CFG_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [mpmm_pkg::POOL_CFG_W-1:0] r_pool_cfg [mpmm_pkg::NUM_POOL_CFG];
    logic [mpmm_pkg::MBOX_CFG_W-1:0] r_task_ids;
    logic [mpmm_pkg::MBOX_CFG_W-1:0] r_signals;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mpmm_pkg::NUM_POOL_CFG; k++) begin
                r_pool_cfg[k] <= mpmm_pkg::POOL_CFG_RESET;
            end
            r_task_ids <= '0;
            r_signals  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mpmm_pkg::CFG_POOL0: begin
                    r_pool_cfg[0] <= i_cfg_data[mpmm_pkg::POOL_CFG_W-1:0];
                end
                mpmm_pkg::CFG_POOL1: begin
                    r_pool_cfg[1] <= i_cfg_data[mpmm_pkg::POOL_CFG_W-1:0];
                end
                mpmm_pkg::CFG_POOL2: begin
                    r_pool_cfg[2] <= i_cfg_data[mpmm_pkg::POOL_CFG_W-1:0];
                end
                mpmm_pkg::CFG_POOL3: begin
                    r_pool_cfg[3] <= i_cfg_data[mpmm_pkg::POOL_CFG_W-1:0];
                end
                mpmm_pkg::CFG_TASK_IDS: begin
                    r_task_ids <= i_cfg_data;
                end
                mpmm_pkg::CFG_SIGNALS: begin
                    r_signals <= i_cfg_data;
                end
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state, the captured item and the pool and mailbox tables.
    // ------------------------------------------------------------------
    mpmm_pkg::t_state r_state, n_state;

    logic [mpmm_pkg::OP_W-1:0] r_op;
    logic [mpmm_pkg::ID_W-1:0] r_mb;
    logic [mpmm_pkg::ID_W-1:0] r_pl;
    logic [MESSAGE_WIDTH-1:0]  r_msg;

    logic [BW-1:0] r_free_head  [NUM_POOLS];
    logic [BW-1:0] r_free_tail  [NUM_POOLS];
    logic [CW-1:0] r_free_count [NUM_POOLS];
    logic [BW-1:0] r_q_head     [NUM_MAILBOXES];
    logic [BW-1:0] r_q_tail     [NUM_MAILBOXES];
    logic [CW-1:0] r_q_count    [NUM_MAILBOXES];
    logic [BW-1:0] n_free_head  [NUM_POOLS];
    logic [BW-1:0] n_free_tail  [NUM_POOLS];
    logic [CW-1:0] n_free_count [NUM_POOLS];
    logic [BW-1:0] n_q_head     [NUM_MAILBOXES];
    logic [BW-1:0] n_q_tail     [NUM_MAILBOXES];
    logic [CW-1:0] n_q_count    [NUM_MAILBOXES];

    // The buffer being moved, and the init walk: next buffer, buffers left for
    // the current pool, and the pool being filled.
    logic [BW-1:0]  r_buf,   n_buf;
    logic [CW-1:0]  r_walk,  n_walk;
    logic [CW-1:0]  r_left,  n_left;
    logic [PCW-1:0] r_ipool, n_ipool;

    // Result being built, and the output register.
    logic [mpmm_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [mpmm_pkg::MSG_IN_W-1:0] r_res_msg,    n_res_msg;
    logic                          r_res_nv,     n_res_nv;
    logic [7:0]                    r_res_task,   n_res_task;
    logic [7:0]                    r_res_sig,    n_res_sig;

    logic                          r_out_valid, n_out_valid;
    logic [mpmm_pkg::STATUS_W-1:0] r_out_status;
    logic [mpmm_pkg::MSG_IN_W-1:0] r_out_msg;
    logic                          r_out_nv;
    logic [7:0]                    r_out_task;
    logic [7:0]                    r_out_sig;
    logic                          out_load;

    // Buffer store ports.
    logic [BW-1:0]            rd_addr;
    logic                     link_we;
    logic [BW-1:0]            link_waddr;
    logic [BW-1:0]            link_wdata;
    logic [BW-1:0]            link_rdata;
    logic                     data_we;
    logic [BW-1:0]            data_waddr;
    logic [MESSAGE_WIDTH-1:0] data_wmsg;
    logic [PW-1:0]            data_wowner;
    logic [MESSAGE_WIDTH-1:0] data_rmsg;
    logic [PW-1:0]            data_rowner;

    mpmm_buf_mem #(
        .DEPTH  (NUM_BUFFERS),
        .BUF_W  (BW),
        .MSG_W  (MESSAGE_WIDTH),
        .POOL_W (PW)
    ) u_buf_mem (
        .i_clk         (i_clk),
        .i_rd_addr     (rd_addr),
        .i_link_we     (link_we),
        .i_link_waddr  (link_waddr),
        .i_link_wdata  (link_wdata),
        .o_link_rdata  (link_rdata),
        .i_data_we     (data_we),
        .i_data_waddr  (data_waddr),
        .i_data_wmsg   (data_wmsg),
        .i_data_wowner (data_wowner),
        .o_data_rmsg   (data_rmsg),
        .o_data_rowner (data_rowner)
    );

    // ------------------------------------------------------------------
    // Decoded ids. All pool table reads go through one select: the pool of
    // the item for a send, the owner of the popped buffer for a receive.
    // ------------------------------------------------------------------
    logic          in_accept;
    logic          bad_pool;
    logic          bad_mb;
    logic [MW-1:0] mb_idx;
    logic [PW-1:0] pl_idx;
    logic [PW-1:0] pool_sel;

    assign in_accept = i_s_tvalid && o_s_tready;
    assign bad_pool  = r_pl >= mpmm_pkg::ID_W'(NUM_POOLS);
    assign bad_mb    = r_mb >= mpmm_pkg::ID_W'(NUM_MAILBOXES);
    assign mb_idx    = r_mb[MW-1:0];
    assign pl_idx    = r_pl[PW-1:0];
    assign pool_sel  = (r_state == mpmm_pkg::S_UPDATE && r_op == mpmm_pkg::OP_RECV)
                       ? data_rowner : pl_idx;

    // Init arithmetic: this pool gets min(configured count, buffers left).
    logic [mpmm_pkg::POOL_CFG_W-1:0] init_cfg;
    logic [LW-1:0]                   init_left;
    logic [CW-1:0]                   init_n;
    logic [CW-1:0]                   init_last;

    assign init_cfg  = r_pool_cfg[2'(r_ipool)];
    assign init_left = LW'(NUM_BUFFERS) - LW'(r_walk);
    assign init_n    = (LW'(init_cfg) < init_left) ? CW'(init_cfg) : CW'(init_left);
    assign init_last = r_walk + init_n - CW'(1);

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_free_tail  = r_free_tail;
        n_free_count = r_free_count;
        n_q_head     = r_q_head;
        n_q_tail     = r_q_tail;
        n_q_count    = r_q_count;
        n_buf        = r_buf;
        n_walk       = r_walk;
        n_left       = r_left;
        n_ipool      = r_ipool;
        n_res_status = r_res_status;
        n_res_msg    = r_res_msg;
        n_res_nv     = r_res_nv;
        n_res_task   = r_res_task;
        n_res_sig    = r_res_sig;
        rd_addr      = r_buf;
        link_we      = 1'b0;
        link_waddr   = r_buf;
        link_wdata   = r_buf;
        data_we      = 1'b0;
        data_waddr   = r_buf;
        data_wmsg    = r_msg;
        data_wowner  = pl_idx;
        out_load     = 1'b0;

        case (r_state)
            mpmm_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = mpmm_pkg::S_DECODE;
                end
            end

            mpmm_pkg::S_DECODE: begin
                n_res_status = mpmm_pkg::ST_OK;
                n_res_msg    = '0;
                n_res_nv     = 1'b0;
                n_res_task   = '0;
                n_res_sig    = '0;
                n_state      = mpmm_pkg::S_DONE;
                case (r_op)
                    mpmm_pkg::OP_INIT: begin
                        for (int k = 0; k < NUM_MAILBOXES; k++) begin
                            n_q_head[k]  = '0;
                            n_q_tail[k]  = '0;
                            n_q_count[k] = '0;
                        end
                        n_walk  = '0;
                        n_left  = '0;
                        n_ipool = '0;
                        n_state = mpmm_pkg::S_INIT_POOL;
                    end
                    mpmm_pkg::OP_SEND: begin
                        // A bad pool id and a bad mailbox id give the same status.
                        if (bad_pool || bad_mb) begin
                            n_res_status = mpmm_pkg::ST_BAD_ID;
                        end else if (r_free_count[pool_sel] == '0) begin
                            n_res_status = mpmm_pkg::ST_POOL_EMPTY;
                        end else begin
                            rd_addr = r_free_head[pool_sel];
                            n_buf   = r_free_head[pool_sel];
                            n_state = mpmm_pkg::S_UPDATE;
                        end
                    end
                    mpmm_pkg::OP_RECV: begin
                        if (bad_mb) begin
                            n_res_status = mpmm_pkg::ST_BAD_ID;
                        end else if (r_q_count[mb_idx] == '0) begin
                            n_res_status = mpmm_pkg::ST_MBOX_EMPTY;
                        end else begin
                            rd_addr = r_q_head[mb_idx];
                            n_buf   = r_q_head[mb_idx];
                            n_state = mpmm_pkg::S_UPDATE;
                        end
                    end
                    default: begin
                        n_res_status = mpmm_pkg::ST_BAD_ID;
                    end
                endcase
            end

            mpmm_pkg::S_UPDATE: begin
                n_state = mpmm_pkg::S_DONE;
                if (r_op == mpmm_pkg::OP_SEND) begin
                    // Pop the pool head, fill the buffer, append it to the mailbox.
                    n_free_head[pool_sel]  = link_rdata;
                    n_free_count[pool_sel] = r_free_count[pool_sel] - CW'(1);
                    data_we = 1'b1;
                    if (r_q_count[mb_idx] == '0) begin
                        n_q_head[mb_idx] = r_buf;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = r_q_tail[mb_idx];
                    end
                    n_q_tail[mb_idx]  = r_buf;
                    n_q_count[mb_idx] = r_q_count[mb_idx] + CW'(1);
                    n_res_nv   = 1'b1;
                    n_res_task = r_task_ids[{mb_idx, 3'b000} +: 8];
                    n_res_sig  = r_signals[{mb_idx, 3'b000} +: 8];
                end else begin
                    // Pop the mailbox head and return the buffer to its owner's tail.
                    n_res_msg         = mpmm_pkg::MSG_IN_W'(data_rmsg);
                    n_q_head[mb_idx]  = link_rdata;
                    n_q_count[mb_idx] = r_q_count[mb_idx] - CW'(1);
                    if (r_free_count[pool_sel] == '0) begin
                        n_free_head[pool_sel] = r_buf;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = r_free_tail[pool_sel];
                    end
                    n_free_tail[pool_sel]  = r_buf;
                    n_free_count[pool_sel] = r_free_count[pool_sel] + CW'(1);
                end
            end

            mpmm_pkg::S_INIT_POOL: begin
                if (r_ipool == PCW'(NUM_POOLS)) begin
                    n_state = mpmm_pkg::S_DONE;
                end else begin
                    // An empty pool keeps head and tail at zero.
                    n_free_head[PW'(r_ipool)]  = (init_n != '0) ? BW'(r_walk) : '0;
                    n_free_tail[PW'(r_ipool)]  = (init_n != '0) ? BW'(init_last) : '0;
                    n_free_count[PW'(r_ipool)] = init_n;
                    n_left = init_n;
                    if (init_n == '0) begin
                        n_ipool = r_ipool + PCW'(1);
                    end else begin
                        n_state = mpmm_pkg::S_INIT_BUF;
                    end
                end
            end

            mpmm_pkg::S_INIT_BUF: begin
                // Link each buffer to the next one of its pool; the last links to itself.
                link_we     = 1'b1;
                link_waddr  = BW'(r_walk);
                link_wdata  = (r_left > CW'(1)) ? BW'(r_walk + CW'(1)) : BW'(r_walk);
                data_we     = 1'b1;
                data_waddr  = BW'(r_walk);
                data_wmsg   = '0;
                data_wowner = PW'(r_ipool);
                n_walk = r_walk + CW'(1);
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_ipool = r_ipool + PCW'(1);
                    n_state = mpmm_pkg::S_INIT_POOL;
                end
            end

            mpmm_pkg::S_DONE: begin
                // Wait for room in the output register.
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = mpmm_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = mpmm_pkg::S_IDLE;
            end
        endcase
    end

    assign n_out_valid = out_load || (r_out_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mpmm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_POOLS; k++) begin
                r_free_head[k]  <= '0;
                r_free_tail[k]  <= '0;
                r_free_count[k] <= '0;
            end
            for (int k = 0; k < NUM_MAILBOXES; k++) begin
                r_q_head[k]  <= '0;
                r_q_tail[k]  <= '0;
                r_q_count[k] <= '0;
            end
            r_walk  <= '0;
            r_left  <= '0;
            r_ipool <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_free_head  <= n_free_head;
            r_free_tail  <= n_free_tail;
            r_free_count <= n_free_count;
            r_q_head     <= n_q_head;
            r_q_tail     <= n_q_tail;
            r_q_count    <= n_q_count;
            r_walk       <= n_walk;
            r_left       <= n_left;
            r_ipool      <= n_ipool;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= i_s_tdata[1:0];
            r_mb  <= i_s_tdata[9:2];
            r_pl  <= i_s_tdata[17:10];
            r_msg <= MESSAGE_WIDTH'(i_s_tdata[49:18]);
        end
        r_buf        <= n_buf;
        r_res_status <= n_res_status;
        r_res_msg    <= n_res_msg;
        r_res_nv     <= n_res_nv;
        r_res_task   <= n_res_task;
        r_res_sig    <= n_res_sig;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_msg    <= r_res_msg;
            r_out_nv     <= r_res_nv;
            r_out_task   <= r_res_task;
            r_out_sig    <= r_res_sig;
        end
    end

    assign o_s_tready = (r_state == mpmm_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b00000, r_out_sig, r_out_task, r_out_nv, r_out_msg, r_out_status};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_notify_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_nv) |-> (r_out_status == mpmm_pkg::ST_OK))
        else $error("notify raised on a failed operation");

    a_msg_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_msg != '0) |-> (r_out_status == mpmm_pkg::ST_OK))
        else $error("message word returned on a failed operation");

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == mpmm_pkg::S_DECODE))
        else $error("accepted item not decoded next cycle");

    a_init_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpmm_pkg::S_INIT_BUF) |-> (r_left != '0 && r_walk < CW'(NUM_BUFFERS)))
        else $error("init walk ran past its pool or the buffer store");

endmodule
